// ===== sv/b64d_pkg.sv =====
package b64d_pkg;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [1:0] STATUS_BYTE        = 2'd0;
    localparam logic [1:0] STATUS_END_OK      = 2'd1;
    localparam logic [1:0] STATUS_END_BAD_LEN = 2'd2;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // work handed from the front to the back: up to three bytes and a status item
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      byte_count;
        logic            has_status;
        logic [1:0]      status;
    } b64d_job_t;

    // bit 6 set means the character is not in the alphabet
    function automatic logic [6:0] symbol_value(input logic [7:0] ch);
        logic [6:0] v;
        v = 7'd64;
        if (ch >= 8'h41 && ch <= 8'h5A)
            v = 7'(ch - 8'h41);
        else if (ch >= 8'h61 && ch <= 8'h7A)
            v = 7'(ch - 8'h61 + 8'd26);
        else if (ch >= 8'h30 && ch <= 8'h39)
            v = 7'(ch - 8'h30 + 8'd52);
        else if (ch == 8'h2B)
            v = 7'd62;
        else if (ch == 8'h2F)
            v = 7'd63;
        return v;
    endfunction

endpackage

// ===== sv/b64d_front.sv =====
module b64d_front
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic [7:0] char_code,
    input  logic      end_of_text,
    output logic      push,
    output b64d_job_t job
);

    logic [17:0] sextet_buffer_reg, sextet_buffer_next;
    logic [1:0]  group_position_reg, group_position_next;
    logic        decoding_stopped_reg, decoding_stopped_next;

    logic [6:0] v;
    logic       is_sym;
    logic [5:0] s0, s1, s2;
    logic [1:0] pos_upd;
    logic       stop_upd;

    assign v      = symbol_value(char_code);
    assign is_sym = ~v[6];
    assign s0     = sextet_buffer_reg[17:12];
    assign s1     = sextet_buffer_reg[11:6];
    assign s2     = sextet_buffer_reg[5:0];

    always_comb
    begin
        sextet_buffer_next    = sextet_buffer_reg;
        group_position_next   = group_position_reg;
        decoding_stopped_next = decoding_stopped_reg;
        job                   = '0;

        if (!decoding_stopped_reg)
        begin
            if (group_position_reg == POS_FIRST)
            begin
                // line breaks between groups are skipped
                if (char_code != CHAR_LF && char_code != CHAR_CR)
                begin
                    sextet_buffer_next  = {(is_sym ? v[5:0] : 6'd0), 12'd0};
                    group_position_next = POS_SECOND;
                end
            end
            else if (!is_sym)
            begin
                case (group_position_reg)
                    POS_SECOND:
                    begin
                        job.byte_count = 2'd1;
                        job.bytes[0]   = {s0, 2'b00};
                    end
                    POS_THIRD:
                    begin
                        job.byte_count = 2'd1;
                        job.bytes[0]   = {s0, s1[5:4]};
                    end
                    default:
                    begin
                        job.byte_count = 2'd2;
                        job.bytes[0]   = {s0, s1[5:4]};
                        job.bytes[1]   = {s1[3:0], s2[5:2]};
                    end
                endcase
                decoding_stopped_next = 1'b1;
                group_position_next   = POS_FIRST;
                sextet_buffer_next    = '0;
            end
            else if (group_position_reg != POS_FOURTH)
            begin
                if (group_position_reg == POS_SECOND)
                    sextet_buffer_next[11:6] = v[5:0];
                else
                    sextet_buffer_next[5:0] = v[5:0];
                group_position_next = group_position_reg + 2'd1;
            end
            else
            begin
                job.byte_count      = 2'd3;
                job.bytes[0]        = {s0, s1[5:4]};
                job.bytes[1]        = {s1[3:0], s2[5:2]};
                job.bytes[2]        = {s2[1:0], v[5:0]};
                group_position_next = POS_FIRST;
                sextet_buffer_next  = '0;
            end
        end

        pos_upd  = group_position_next;
        stop_upd = decoding_stopped_next;

        if (end_of_text)
        begin
            job.has_status = 1'b1;
            job.status     = (pos_upd != POS_FIRST && !stop_upd) ? STATUS_END_BAD_LEN
                                                                 : STATUS_END_OK;
            sextet_buffer_next    = '0;
            group_position_next   = POS_FIRST;
            decoding_stopped_next = 1'b0;
        end
    end

    assign push = accept && (job.has_status || job.byte_count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sextet_buffer_reg    <= '0;
            group_position_reg   <= POS_FIRST;
            decoding_stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            sextet_buffer_reg    <= sextet_buffer_next;
            group_position_reg   <= group_position_next;
            decoding_stopped_reg <= decoding_stopped_next;
        end
    end

endmodule

// ===== sv/b64d_queue.sv =====
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  b64d_job_t wr_job,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output b64d_job_t rd_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64d_job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign rd_job    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/b64d_back.sv =====
module b64d_back
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  b64d_job_t job,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [7:0] data_byte,
    output logic [1:0] status,
    output logic      last_of_run
);

    b64d_job_t  job_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] total;
    logic       xfer;

    assign total       = {1'b0, job_reg.byte_count} + {2'b00, job_reg.has_status};
    assign last_of_run = ({1'b0, idx_reg} + 3'd1) == total;
    assign out_valid   = busy_reg;
    assign xfer        = busy_reg && out_ready;
    assign pop         = job_valid && (!busy_reg || (xfer && last_of_run));

    always_comb
    begin
        data_byte = 8'd0;
        status    = job_reg.status;
        if (idx_reg < job_reg.byte_count)
        begin
            status = STATUS_BYTE;
            case (idx_reg)
                2'd0:    data_byte = job_reg.bytes[0];
                2'd1:    data_byte = job_reg.bytes[1];
                2'd2:    data_byte = job_reg.bytes[2];
                default: data_byte = 8'd0;
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
        else if (xfer && last_of_run)
            busy_next = 1'b0;
        else if (xfer)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

// ===== sv/base64_stream_decoder_core.sv =====
// path: each job is queued, then loaded into the back end's job register (front, queue, back)
// throughput: one character per cycle while the job queue has room; the back end
// sends one result per cycle while m_tready is high, and drains up to four per character
// the queue depth (QUEUE_DEPTH jobs) sets how long the input runs ahead of the output
// reset: rst_n asynchronous, active low; clears group state, queue and output side
module base64_stream_decoder_core
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [1:0] status
    output logic       m_tlast    // last_of_run
);

    logic      accept;
    logic      push;
    logic      full;
    logic      not_empty;
    logic      pop;
    b64d_job_t wr_job;
    b64d_job_t rd_job;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    b64d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (s_tdata),
        .end_of_text (s_tlast),
        .push        (push),
        .job         (wr_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_job    (wr_job),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_job    (rd_job)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (not_empty),
        .job         (rd_job),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .data_byte   (m_tdata),
        .status      (m_tuser),
        .last_of_run (m_tlast)
    );

endmodule
